FILE: rtl/core/assert_macros.svh
// Assertion macros used by the merge block RTL.
// Expects signals named clk and arst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define SSMD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define SSMD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/ssmd_pkg.sv
// Package for the sorted stream merge: sizes, the candidate word type
// and the active-stream mask helper. No dependencies.
package ssmd_pkg;

	localparam int NUM_STREAMS = 8;
	localparam int KEY_WIDTH   = 64;
	localparam int IDX_W       = $clog2(NUM_STREAMS);
	localparam int CNT_W       = 4;

	localparam logic [CNT_W-1:0] CNT_RESET = 4'd8;

	// Running minimum handed from cell to cell.
	typedef struct packed {
		logic                 found;
		logic [KEY_WIDTH-1:0] key;
		logic [IDX_W-1:0]     idx;
		logic [31:0]          payload;
	} cand_t;

	// Streams 0 .. count-1 take part; zero acts as one, large values clamp.
	function automatic logic [NUM_STREAMS-1:0] active_mask(input logic [CNT_W-1:0] cnt);
		logic [NUM_STREAMS-1:0] m;
		int n;
		n = int'(cnt);
		if (n < 1) begin
			n = 1;
		end
		if (n > NUM_STREAMS) begin
			n = NUM_STREAMS;
		end
		for (int i = 0; i < NUM_STREAMS; i++) begin
			m[i] = (i < n);
		end
		return m;
	endfunction

endpackage

FILE: rtl/core/ssmd_cell.sv
// One merge cell: holds one stream's head, live and awaiting bits, and
// folds its head into the running minimum. Depends on ssmd_pkg.
module ssmd_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ssmd_pkg::IDX_W-1:0]    cell_id,
	input  logic                          await_rst,
	input  logic                          act,
	input  logic                          restart,
	input  logic                          act_new,
	input  logic                          ld,
	input  logic                          ended,
	input  logic [ssmd_pkg::KEY_WIDTH-1:0] key_in,
	input  logic [31:0]                   payload_in,
	input  logic                          refill,
	input  logic [ssmd_pkg::KEY_WIDTH-1:0] best_key,
	input  ssmd_pkg::cand_t               cand_prev,
	output ssmd_pkg::cand_t               cand_q,
	output logic                          live_q,
	output logic                          await_q,
	output logic                          match
);

	logic [ssmd_pkg::KEY_WIDTH-1:0] key_q;
	logic [31:0]                    payload_q;
	logic                           take;

	// Head storage, written only by a non-ended word
	always_ff @(posedge clk) begin
		if (ld && !ended) begin
			key_q     <= key_in;
			payload_q <= payload_in;
		end
	end

	// Live and awaiting flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q  <= 1'b1;
			await_q <= await_rst;
		end else if (restart) begin
			live_q  <= 1'b1;
			await_q <= act_new;
		end else if (ld) begin
			await_q <= 1'b0;
			if (ended) begin
				live_q <= 1'b0;
			end
		end else if (refill) begin
			await_q <= match;
		end
	end

	// Equal-key detect against the winning key
	assign match = live_q && act && (key_q == best_key);

	// Strict compare keeps the lower index on a tie
	assign take = live_q && act && (!cand_prev.found || (key_q < cand_prev.key));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
		end else if (take) begin
			cand_q <= '{found: 1'b1, key: key_q, idx: cell_id, payload: payload_q};
		end else begin
			cand_q <= cand_prev;
		end
	end

endmodule

FILE: rtl/core/sorted_stream_merge_dedup.sv
// A head word that leaves no stream awaiting starts a sweep: the minimum ripples
// through the cell chain while the sequencer steps through ST_SWEEP and ST_FINISH.
// Other head words are taken one per cycle while the sequencer is idle; a completing
// word holds off input until its result is registered, which waits while the result slot is stalled.
// Reset: every stream live, streams 0..7 awaiting, stream_count 8, no result held.
// Top level of the sorted stream merge. Depends on ssmd_pkg, ssmd_cell, assert_macros.svh.
`include "assert_macros.svh"

module sorted_stream_merge_dedup (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        stream_count_we,
	input  logic [3:0]  stream_count_wdata,
	input  logic        head_valid,
	output logic        head_stall,
	input  logic [2:0]  stream_index,
	input  logic [63:0] head_key,
	input  logic [31:0] head_payload,
	input  logic        stream_ended,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [63:0] out_key,
	output logic [31:0] out_payload,
	output logic [2:0]  source_stream,
	output logic [7:0]  refill_mask,
	output logic        merge_done
);

	localparam int N = ssmd_pkg::NUM_STREAMS;

	typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_FINISH} state_t;

	state_t                          state_q;
	logic [ssmd_pkg::IDX_W-1:0]      cnt_q;
	logic [ssmd_pkg::CNT_W-1:0]      count_q;
	logic [ssmd_pkg::KEY_WIDTH-1:0]  res_key_q;
	logic [31:0]                     res_payload_q;
	logic [ssmd_pkg::IDX_W-1:0]      src_q;
	logic [N-1:0]                    refill_q;
	logic                            done_q;

	logic [N-1:0]  act, act_new, rst_act, sel, ld;
	logic [N-1:0]  live_vec, await_vec, match_vec;
	logic          accept, hit, last, slot_free, refill_go, all_ended;
	ssmd_pkg::cand_t cand [N+1];

	assign act     = ssmd_pkg::active_mask(count_q);
	assign act_new = ssmd_pkg::active_mask(stream_count_wdata);
	assign rst_act = ssmd_pkg::active_mask(ssmd_pkg::CNT_RESET);

	// Input decode: a word counts only for an active stream that is awaiting
	assign head_stall = (state_q != ST_IDLE);
	assign accept     = head_valid && !head_stall;
	assign hit        = |(sel & act & await_vec);
	assign last       = accept && hit && ((await_vec & act & ~sel) == '0);
	assign ld         = (accept ? sel : '0) & act & await_vec;

	assign slot_free = !result_valid || !result_stall;
	assign all_ended = ((live_vec & act) == '0);
	assign refill_go = (state_q == ST_FINISH) && slot_free && !all_ended;

	assign cand[0] = '0;

	// Cell chain
	for (genvar i = 0; i < N; i++) begin : g_cell
		assign sel[i] = (32'(stream_index) == i);

		ssmd_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cell_id    (ssmd_pkg::IDX_W'(i)),
			.await_rst  (rst_act[i]),
			.act        (act[i]),
			.restart    (stream_count_we),
			.act_new    (act_new[i]),
			.ld         (ld[i]),
			.ended      (stream_ended),
			.key_in     (head_key[ssmd_pkg::KEY_WIDTH-1:0]),
			.payload_in (head_payload),
			.refill     (refill_go),
			.best_key   (cand[N].key),
			.cand_prev  (cand[i]),
			.cand_q     (cand[i+1]),
			.live_q     (live_vec[i]),
			.await_q    (await_vec[i]),
			.match      (match_vec[i])
		);
	end

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			count_q       <= ssmd_pkg::CNT_RESET;
			result_valid  <= 1'b0;
			res_key_q     <= '0;
			res_payload_q <= '0;
			src_q         <= '0;
			refill_q      <= '0;
			done_q        <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				result_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (last) begin
						state_q <= ST_SWEEP;
						cnt_q   <= '0;
					end
				end
				ST_SWEEP: begin
					if (cnt_q == ssmd_pkg::IDX_W'(N - 1)) begin
						state_q <= ST_FINISH;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FINISH: begin
					if (slot_free) begin
						result_valid <= 1'b1;
						state_q      <= ST_IDLE;
						if (all_ended) begin
							res_key_q     <= '0;
							res_payload_q <= '0;
							src_q         <= '0;
							refill_q      <= '0;
							done_q        <= 1'b1;
						end else begin
							res_key_q     <= cand[N].key;
							res_payload_q <= cand[N].payload;
							src_q         <= cand[N].idx;
							refill_q      <= match_vec;
							done_q        <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (stream_count_we) begin
				count_q <= stream_count_wdata;
				state_q <= ST_IDLE;
			end
		end
	end

	assign out_key       = 64'(res_key_q);
	assign out_payload   = res_payload_q;
	assign source_stream = 3'(src_q);
	assign refill_mask   = 8'(refill_q);
	assign merge_done    = done_q;

	// No stream may be awaiting while the minimum is being formed
	`SSMD_ASSERT(a_no_await_in_sweep, (state_q != ST_IDLE) |-> ((await_vec & act) == '0), "stream awaiting during sweep")
	// A normal result always names its source in the refill set
	`SSMD_ASSERT(a_src_refills, (result_valid && !done_q) |-> refill_q[src_q], "source stream not in refill set")
	// Refill happens only when a live minimum was found
	`SSMD_ASSERT_ALWAYS(a_refill_found, refill_go |-> cand[N].found, "refill without a live minimum")

endmodule
